// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, constants and the character map for the base64 stream encoder.
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'd63;

    // number of message bytes that a group carries
    localparam logic [1:0] USED_ONE   = 2'd1;
    localparam logic [1:0] USED_TWO   = 2'd2;
    localparam logic [1:0] USED_THREE = 2'd3;

    // character position inside a group
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  used;
        logic        fin;
    } t_group;

    // sextet to ASCII, standard alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/base64_stream_encoder.sv =====
// A byte that closes a group is written into the group queue, and the back end
// loads its first character from there. Throughput: one character per cycle
// while the receiver is ready, so input sustains three bytes per four characters.
// Bytes that only fill the pending buffer are taken every cycle, even while
// the group queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous active low; clears pending bytes, queue and output valid.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    b64e_pkg::t_group push_group;
    b64e_pkg::t_group head_group;
    logic             push;
    logic             pop;
    logic             q_ready;
    logic             q_valid;
    logic [CW-1:0]    q_count;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_group      (push_group),
        .i_q_ready    (q_ready)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_group (head_group),
        .o_count (q_count)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_group     (head_group),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready)
        else $error("group pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("group popped from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_last_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |-> (o_out_char != 8'h00))
        else $error("last beat without a character");
`endif

endmodule

// ===== hw/rtl/b64e_front.sv =====
// Front end: accepts bytes, holds pending bytes, forms groups for the queue.
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_final_byte,
    output logic                o_push,
    output b64e_pkg::t_group    o_group,
    input  logic                i_q_ready
);

    logic [15:0] r_pend;
    logic [1:0]  r_cnt;
    logic [15:0] n_pend;
    logic [1:0]  n_cnt;
    logic        completes;
    logic        emit;
    logic        accept;

    // a count of three cannot occur; it is handled like two
    assign completes = r_cnt[1];
    assign emit      = completes || i_final_byte;
    assign o_ready   = !emit || i_q_ready;
    assign accept    = i_valid && o_ready;
    assign o_push    = accept && emit;

    always_comb begin
        o_group.fin = i_final_byte;
        if (completes) begin
            o_group.bits = {r_pend, i_data_byte};
            o_group.used = b64e_pkg::USED_THREE;
        end else if (r_cnt == 2'd1) begin
            o_group.bits = {r_pend[7:0], i_data_byte, 8'h00};
            o_group.used = b64e_pkg::USED_TWO;
        end else begin
            o_group.bits = {i_data_byte, 16'h0000};
            o_group.used = b64e_pkg::USED_ONE;
        end
    end

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (emit) begin
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
            end else begin
                n_pend = {r_pend[7:0], i_data_byte};
                n_cnt  = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'h0000;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// Short group queue between the front and back ends.
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  b64e_pkg::t_group            i_group,
    output logic                        o_ready,
    input  logic                        i_pop,
    output logic                        o_valid,
    output b64e_pkg::t_group            o_group,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_group = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back end: turns one queued group into four characters, one beat per cycle if ready.
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  b64e_pkg::t_group    i_group,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_char,
    output logic                o_last_char
);

    logic [1:0] r_pos;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       load;
    logic [5:0] sextet;
    logic       pad;
    logic [7:0] n_char;

    assign load  = i_q_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_pos == b64e_pkg::POS_FOURTH);

    always_comb begin
        sextet = '0;
        pad    = 1'b0;
        case (r_pos)
            b64e_pkg::POS_FIRST:  sextet = i_group.bits[23:18];
            b64e_pkg::POS_SECOND: sextet = i_group.bits[17:12];
            b64e_pkg::POS_THIRD: begin
                sextet = i_group.bits[11:6];
                pad    = (i_group.used == b64e_pkg::USED_ONE);
            end
            default: begin
                sextet = i_group.bits[5:0];
                pad    = (i_group.used != b64e_pkg::USED_THREE);
            end
        endcase
        n_char = pad ? b64e_pkg::PAD_CHAR
                     : b64e_pkg::sextet_char(sextet & b64e_pkg::SEXTET_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_last <= i_group.fin && (r_pos == b64e_pkg::POS_FOURTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= b64e_pkg::POS_FIRST;
            r_valid <= 1'b0;
        end else if (load) begin
            r_pos   <= r_pos + 2'd1;
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

// ===== tb/base64_stream_encoder_tb.sv =====
// Self-checking testbench for base64_stream_encoder with a built-in encoder predictor.
module base64_stream_encoder_tb;

    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  RX_HOLD_CYCLES = 96;
    localparam int  IDLE_PCT       = 37;
    localparam int  DRAIN_CYCLES   = 16;
    localparam logic LAST_BYTE     = 1'b1;
    localparam logic MORE_BYTES    = 1'b0;
    localparam logic [511:0] CHARSET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_final_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_char;
    logic       o_last_char;

    t_enc_char   expected_chars[$];
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    int          mismatch_count;
    int          stalled_cycles;
    bit          sender_calm;
    bit          rx_calm;
    bit          rx_hold_req;

    base64_stream_encoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        return CHARSET[511 - 8 * idx -: 8];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // Advance the encoder state by one accepted byte, queue any characters it yields.
    task automatic encode_byte(input logic [7:0] data, input logic fin);
        logic [23:0] grp;
        logic [1:0]  used;
        t_enc_char   c;
        if (held_count >= b64e_pkg::USED_TWO) begin
            grp  = {held_bytes, data};
            used = b64e_pkg::USED_THREE;
        end else if (fin) begin
            if (held_count == b64e_pkg::USED_ONE) begin
                grp  = {held_bytes[7:0], data, 8'h00};
                used = b64e_pkg::USED_TWO;
            end else begin
                grp  = {data, 16'h0000};
                used = b64e_pkg::USED_ONE;
            end
        end else begin
            held_bytes = {held_bytes[7:0], data};
            held_count = held_count + 2'd1;
            return;
        end
        c.last = 1'b0;
        c.ch = b64_char(grp[23:18]);
        expected_chars.push_back(c);
        c.ch = b64_char(grp[17:12]);
        expected_chars.push_back(c);
        c.ch = (used >= b64e_pkg::USED_TWO) ? b64_char(grp[11:6]) : b64e_pkg::PAD_CHAR;
        expected_chars.push_back(c);
        c.ch   = (used == b64e_pkg::USED_THREE) ? b64_char(grp[5:0]) : b64e_pkg::PAD_CHAR;
        c.last = fin;
        expected_chars.push_back(c);
        held_bytes = '0;
        held_count = '0;
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    // Valid is left high so back-to-back beats need no extra assignment.
    task automatic send_byte(input logic [7:0] data, input logic fin);
        while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= data;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_ready);
        encode_byte(data, fin);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), (i == len - 1) ? LAST_BYTE : MORE_BYTES);
        end
    endtask

    task automatic test_directed_groups();
        // lone final byte, both extremes: two chars plus "=="
        send_byte(8'h00, LAST_BYTE);
        send_byte(8'hFF, LAST_BYTE);
        // one byte waiting when the final arrives: three chars plus "="
        send_byte(8'hFB, MORE_BYTES);
        send_byte(8'hEF, LAST_BYTE);
        // full groups closed by the final byte
        send_byte(8'h00, MORE_BYTES);
        send_byte(8'h00, MORE_BYTES);
        send_byte(8'h00, LAST_BYTE);
        send_byte(8'hFF, MORE_BYTES);
        send_byte(8'hFF, MORE_BYTES);
        send_byte(8'hFF, LAST_BYTE);
        // "++++" group not marked last, then a lone trailing byte
        send_byte(8'hFB, MORE_BYTES);
        send_byte(8'hEF, MORE_BYTES);
        send_byte(8'hBE, MORE_BYTES);
        send_byte(8'h4D, LAST_BYTE);
        // group, then one byte waiting when the final arrives
        send_byte(8'h12, MORE_BYTES);
        send_byte(8'h34, MORE_BYTES);
        send_byte(8'h56, MORE_BYTES);
        send_byte(8'h78, MORE_BYTES);
        send_byte(8'h9A, LAST_BYTE);
    endtask

    task automatic test_random_messages(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_message(len);
            sent += len;
        end
    endtask

    task automatic test_steady_stream();
        sender_calm = 1'b1;
        rx_calm     = 1'b1;
        send_message(14);
        send_message(16);
        sender_calm = 1'b0;
        rx_calm     = 1'b0;
    endtask

    task automatic test_output_backpressure();
        sender_calm = 1'b1;
        rx_hold_req = 1'b1;
        send_message(20);
        sender_calm = 1'b0;
    endtask

    // receiver: random stalls, or a long counted hold-off on request
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                i_ready <= rx_calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_enc_char want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %02h last=%0b",
                                          o_out_char, o_last_char));
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    report_mismatch($sformatf("out_char got %02h want %02h",
                                              o_out_char, want.ch));
                end
                if (o_last_char !== want.last) begin
                    report_mismatch($sformatf("last_char got %0b want %0b on char %02h",
                                              o_last_char, want.last, want.ch));
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    initial begin
        stalled_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("base64_stream_encoder_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        mismatch_count = 0;
        held_bytes     = '0;
        held_count     = '0;
        sender_calm    = 1'b0;
        rx_calm        = 1'b0;
        rx_hold_req    = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= 8'h00;
        i_final_byte <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_groups();
        test_random_messages(130);
        test_steady_stream();
        test_output_backpressure();
        test_random_messages(20);

        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("base64_stream_encoder_tb OK");
        end else begin
            $display("base64_stream_encoder_tb NOT OK");
        end
        $finish;
    end

endmodule
